// File: rtl/assert_macros.svh
// Assertion macros used by rtl/bitmap_first_free_allocator.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BFA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bitmap allocator check failed");

`define BFA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator check failed");

`else

`define BFA_ASSERT(lbl, prop)

`define BFA_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// File: rtl/bfa_pkg.sv
package bfa_pkg;

	localparam int WORD_W = 8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_WORDS = 1'b0;
	localparam logic REG_BASE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_NOTSET = 2'd3
	} status_t;

	typedef struct packed {
		logic             any;
		logic [4:0]       pos;
	} bit_find_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [WORD_W-1:0] word;
	} scan_res_t;

	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] word;
		logic              full;
	} sum_upd_t;

	function automatic bit_find_t lowest_set(input logic [31:0] v);
		logic [31:0] oh;
		bit_find_t   r;
		oh    = v & (~v + 32'd1);
		r.any = |v;
		r.pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (oh[i]) begin
				r.pos = r.pos | 5'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/bfa_ram.sv
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bfa_regs.sv
module bfa_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [bfa_pkg::WORD_W-1:0] words_in_use,
	output logic [15:0]               bitmap_base_block
);

	import bfa_pkg::*;

	logic [WORD_W-1:0] words_q;
	logic [15:0]       base_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= 8'd128;
			base_q  <= 16'd1;
		end else if (wr_en) begin
			if (paddr[2] == REG_WORDS) begin
				words_q <= pwdata[WORD_W-1:0];
			end else begin
				base_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_WORDS) begin
			prdata = {24'd0, words_q};
		end else begin
			prdata = {16'd0, base_q};
		end
	end

	assign words_in_use      = words_q;
	assign bitmap_base_block = base_q;

endmodule

// File: rtl/bfa_scan.sv
module bfa_scan #(
	parameter int MAX_WORDS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bfa_pkg::WORD_W-1:0] n,
	input  bfa_pkg::sum_upd_t          upd,
	output bfa_pkg::scan_res_t         res
);

	import bfa_pkg::*;

	localparam int NCHUNK = (MAX_WORDS + 31) / 32;
	localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int CMPW   = (CW + 6 > 9) ? CW + 6 : 9;

	// One flag per bitmap word, set while that word has no clear bit.
	logic [NCHUNK-1:0][31:0] full_q;
	logic                    busy_q;
	logic [CW-1:0]           chunk_q;
	bit_find_t               lw;
	logic [CW+4:0]           word_wide;
	logic [CMPW-1:0]         next_start;
	logic                    last;
	logic                    in_range;

	always_comb begin
		lw         = lowest_set(~full_q[chunk_q]);
		word_wide  = {chunk_q, lw.pos};
		in_range   = CMPW'(word_wide) < CMPW'(n);
		next_start = (CMPW'(chunk_q) + CMPW'(1)) << 5;
		last       = (chunk_q == CW'(NCHUNK - 1)) || (next_start >= CMPW'(n));
		res.done   = busy_q && (lw.any || last);
		res.found  = busy_q && lw.any && in_range;
		res.word   = WORD_W'(word_wide);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chunk_q <= '0;
			full_q  <= '0;
		end else begin
			if (start) begin
				busy_q  <= 1'b1;
				chunk_q <= '0;
			end else if (busy_q) begin
				if (res.done) begin
					busy_q <= 1'b0;
				end else begin
					chunk_q <= chunk_q + CW'(1);
				end
			end
			if (upd.en) begin
				full_q[CW'(upd.word >> 5)][upd.word[4:0]] <= upd.full;
			end
		end
	end

endmodule

// File: rtl/bitmap_first_free_allocator.sv
// Bitmap first-fit allocator.
// Requests arrive on the s_axis channel: tuser is the operation (allocate or
// free) and tdata carries the entry index to free. Each request yields exactly
// one result transaction on the m_axis channel: tuser is the status and tdata
// the entry number, bitmap disk block, word offset and bit position.
// The bitmap words live in a single-port-read RAM; a flag per word marks it
// full, and a scanner walks those flags 32 words per cycle to pick the word.
// A free reads its bitmap word when accepted and goes to S_MOD; an allocate
// passes through S_SCAN first, where the scanner steps over each 32-word
// group of full words, then S_MOD, which loads the output register. One
// request is in flight at a time (s_axis_tready is high only in S_IDLE);
// the RAM read and write-back set the pace.
// After reset the block sweeps the RAM to zero, one word a cycle through all
// MAX_WORDS words, with s_axis_tready low; the APB port works during that.
// A result waits in the output register while m_axis_tready is low; the next
// request is still accepted and runs up to its write-back, then holds.
// Registers: 0x0 words_in_use (reset 128), 0x4 bitmap_base_block (reset 1).
`include "assert_macros.svh"

module bitmap_first_free_allocator #(
	parameter int MAX_WORDS       = 128,
	parameter int WORDS_PER_BLOCK = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // entry_index[11:0], zero[15:12]
	input  logic        s_axis_tuser,  // operation[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// entry_number[11:0], disk_block[27:12], word_offset[37:28],
	// bit_position[42:38], zero[47:43]
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import bfa_pkg::*;

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_MOD   = 4'b1000
	} state_t;

	function automatic logic [255:0][7:0] quot_tbl();
		logic [255:0][7:0] t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 8'(i / WORDS_PER_BLOCK);
		end
		return t;
	endfunction

	function automatic logic [255:0][7:0] rem_tbl();
		logic [255:0][7:0] t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 8'(i % WORDS_PER_BLOCK);
		end
		return t;
	endfunction

	localparam logic [255:0][7:0] QUOT_TBL = quot_tbl();
	localparam logic [255:0][7:0] REM_TBL  = rem_tbl();

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic              op_q;
	logic [11:0]       idx_q;
	logic [WORD_W-1:0] word_q;
	status_t           err_q;

	logic              out_vld_q;
	status_t           out_status_q;
	logic [11:0]       out_entry_q;
	logic [15:0]       out_disk_q;
	logic [9:0]        out_off_q;
	logic [4:0]        out_bit_q;

	logic [WORD_W-1:0] words_in_use;
	logic [15:0]       base_block;
	logic [WORD_W-1:0] n;
	logic              in_fire;
	logic              free_bad;
	logic              scan_start;
	scan_res_t         scan_res;
	sum_upd_t          upd;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [31:0]       rd_data;

	bit_find_t         zero_find;
	logic [4:0]        bitpos;
	logic [31:0]       bit_oh;
	logic [31:0]       new_word;
	logic              mod_fire;
	status_t           mod_status;

	bfa_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.words_in_use      (words_in_use),
		.bitmap_base_block (base_block)
	);

	bfa_scan #(
		.MAX_WORDS (MAX_WORDS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.n      (n),
		.upd    (upd),
		.res    (scan_res)
	);

	bfa_ram #(
		.WIDTH (32),
		.DEPTH (MAX_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		if (32'(words_in_use) > 32'(MAX_WORDS)) begin
			n = WORD_W'(MAX_WORDS);
		end else begin
			n = words_in_use;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign free_bad      = (13'(s_axis_tdata[11:0]) >= {n, 5'd0}) ||
		(32'(s_axis_tdata[11:5]) >= 32'(MAX_WORDS));
	assign scan_start    = in_fire && (s_axis_tuser == OP_ALLOC);

	always_comb begin
		zero_find = lowest_set(~rd_data);
		bitpos    = (op_q == OP_ALLOC) ? zero_find.pos : idx_q[4:0];
		bit_oh    = 32'd1 << bitpos;
		new_word  = (op_q == OP_ALLOC) ? (rd_data | bit_oh) : (rd_data & ~bit_oh);
		mod_fire  = (state_q == S_MOD) && (!out_vld_q || m_axis_tready);
		mod_status = err_q;
		if (err_q == ST_OK && op_q == OP_FREE && !rd_data[bitpos]) begin
			mod_status = ST_NOTSET;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = AW'(s_axis_tdata[11:5]);
		if (in_fire && s_axis_tuser == OP_FREE && !free_bad) begin
			ram_re = 1'b1;
		end else if (state_q == S_SCAN && scan_res.found) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(scan_res.word);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(word_q);
		ram_wdata = new_word;
		upd.en    = 1'b0;
		upd.word  = word_q;
		upd.full  = (op_q == OP_ALLOC) && (&new_word);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (mod_fire && mod_status == ST_OK) begin
			ram_we = 1'b1;
			upd.en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			err_q     <= ST_OK;
			out_vld_q <= 1'b0;
		end else begin
			if (mod_fire) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser == OP_ALLOC) begin
							err_q   <= ST_OK;
							state_q <= S_SCAN;
						end else begin
							err_q   <= free_bad ? ST_RANGE : ST_OK;
							state_q <= S_MOD;
						end
					end
				end
				S_SCAN: begin
					if (scan_res.done) begin
						if (!scan_res.found) begin
							err_q <= ST_FULL;
						end
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= s_axis_tuser;
			idx_q  <= s_axis_tdata[11:0];
			word_q <= WORD_W'(s_axis_tdata[11:5]);
		end else if (state_q == S_SCAN && scan_res.found) begin
			word_q <= scan_res.word;
		end
		if (mod_fire) begin
			out_status_q <= mod_status;
			if (mod_status == ST_OK) begin
				out_entry_q <= {word_q[6:0], bitpos};
				out_disk_q  <= base_block + 16'(QUOT_TBL[word_q]);
				out_off_q   <= 10'(REM_TBL[word_q]);
				out_bit_q   <= bitpos;
			end else begin
				out_entry_q <= '0;
				out_disk_q  <= '0;
				out_off_q   <= '0;
				out_bit_q   <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {5'd0, out_bit_q, out_off_q, out_disk_q, out_entry_q};

	`BFA_ASSERT_IMPL(a_found_in_range, scan_res.found, 32'(scan_res.word) < 32'(n))
	`BFA_ASSERT_IMPL(a_write_only_ok, ram_we && state_q != S_CLEAR, mod_status == ST_OK)
	`BFA_ASSERT_IMPL(a_result_follows_mod, $past(mod_fire), m_axis_tvalid)

endmodule
